[rtl/u16u8_pkg.sv]
package u16u8_pkg;

    // Default depth of the queue between the front and back halves.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Surrogate ranges and the supplementary plane base.
    localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE       = 21'h10000;

    // Code point limits for the one, two and three byte forms.
    localparam logic [20:0] LIMIT_1BYTE = 21'h00080;
    localparam logic [20:0] LIMIT_2BYTE = 21'h00800;
    localparam logic [20:0] LIMIT_3BYTE = 21'h10000;

    // UTF-8 lead and continuation byte prefixes.
    localparam logic [2:0] LEAD2_PREFIX = 3'b110;
    localparam logic [3:0] LEAD3_PREFIX = 4'b1110;
    localparam logic [4:0] LEAD4_PREFIX = 5'b11110;
    localparam logic [1:0] CONT_PREFIX  = 2'b10;

    // Most bytes one item can produce: a flushed surrogate plus a BMP unit.
    localparam int MAX_BYTES = 6;
    localparam int LEN_W     = 3;

    // Encoding of one code point, bytes left-aligned, first byte on top.
    typedef struct packed {
        logic [31:0]      bytes;
        logic [LEN_W-1:0] len;
    } cp_enc_t;

    // One queued item: all of its output bytes, first byte on top.
    typedef struct packed {
        logic [8*MAX_BYTES-1:0] bytes;
        logic [LEN_W-1:0]       len;
        logic                   string_last;
    } job_t;

    // Encodes one code point of up to 21 bits as UTF-8.
    function automatic cp_enc_t encode_cp(input logic [20:0] cp);
        cp_enc_t r;
        if (cp < LIMIT_1BYTE) begin
            r.bytes = {cp[7:0], 24'h0};
            r.len   = LEN_W'(1);
        end else if (cp < LIMIT_2BYTE) begin
            r.bytes = {LEAD2_PREFIX, cp[10:6], CONT_PREFIX, cp[5:0], 16'h0};
            r.len   = LEN_W'(2);
        end else if (cp < LIMIT_3BYTE) begin
            r.bytes = {LEAD3_PREFIX, cp[15:12], CONT_PREFIX, cp[11:6],
                       CONT_PREFIX, cp[5:0], 8'h0};
            r.len   = LEN_W'(3);
        end else begin
            r.bytes = {LEAD4_PREFIX, cp[20:18], CONT_PREFIX, cp[17:12],
                       CONT_PREFIX, cp[11:6], CONT_PREFIX, cp[5:0]};
            r.len   = LEN_W'(4);
        end
        return r;
    endfunction

endpackage

[rtl/utf16_to_utf8_transcoder.sv]
// UTF-16 to UTF-8 transcoder. Each input item is one UTF-16 code unit with a flag
// for the last unit of a string; each result item is one UTF-8 byte, with run_last
// on the last byte an input item caused and string_done on the last byte of the
// string. A high surrogate that is not last is held and produces nothing; a
// following low surrogate completes a four-byte sequence, anything else first
// flushes the held surrogate as three bytes. Lone surrogates come out as
// three-byte sequences. The front half classifies and encodes one unit per cycle
// into a queue of QUEUE_DEPTH items; the back half sends one byte per cycle from
// a registered output while the output is taken. An input item yields zero to six
// bytes at the output, and the input accepts one item per cycle while the queue
// has room. The first byte of an item passes through the queue, the current-item
// register and the output register before it appears.
module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] s_code_unit,
    input  logic        s_string_last,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_run_last,
    output logic        m_string_done,
    output logic        m_valid,
    input  logic        m_ready
);

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_not_empty;
    u16u8_pkg::job_t  push_job;
    u16u8_pkg::job_t  pop_job;

    assign s_ready = !q_full;

    // Front half: surrogate pairing and encoding.
    u16u8_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .code_unit   (s_code_unit),
        .string_last (s_string_last),
        .accept      (s_valid && s_ready),
        .push        (q_push),
        .job         (push_job)
    );

    // Queue of encoded items.
    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_job   (pop_job)
    );

    // Back half: byte serializer.
    u16u8_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_job       (pop_job),
        .q_pop       (q_pop),
        .out_byte    (m_out_byte),
        .run_last    (m_run_last),
        .string_done (m_string_done),
        .out_valid   (m_valid),
        .out_ready   (m_ready)
    );

endmodule

[rtl/u16u8_front.sv]
module u16u8_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [15:0]          code_unit,
    input  logic                 string_last,
    input  logic                 accept,
    output logic                 push,
    output u16u8_pkg::job_t      job
);

    logic       held_valid_reg;
    logic       held_valid_next;
    logic [9:0] held_bits_reg;
    logic [9:0] held_bits_next;

    logic                 is_high;
    logic                 is_low;
    logic                 pair;
    logic                 flush_held;
    logic                 has_main;
    logic [20:0]          main_cp;
    u16u8_pkg::cp_enc_t   held_enc;
    u16u8_pkg::cp_enc_t   main_enc;

    // Classify the incoming unit.
    assign is_high = (code_unit >= u16u8_pkg::HIGH_SURR_FIRST) &&
                     (code_unit <= u16u8_pkg::HIGH_SURR_LAST);
    assign is_low  = (code_unit >= u16u8_pkg::LOW_SURR_FIRST) &&
                     (code_unit <= u16u8_pkg::LOW_SURR_LAST);

    // Decide what the item produces and what stays held.
    always_comb begin
        pair            = held_valid_reg && is_low;
        flush_held      = held_valid_reg && !is_low;
        has_main        = 1'b1;
        main_cp         = {5'h0, code_unit};
        held_valid_next = held_valid_reg;
        held_bits_next  = held_bits_reg;
        if (pair) begin
            main_cp = u16u8_pkg::SUPP_BASE + {1'b0, held_bits_reg, code_unit[9:0]};
        end else if (is_high && !string_last) begin
            has_main = 1'b0;
        end
        if (accept) begin
            held_valid_next = !pair && is_high && !string_last;
            held_bits_next  = (!pair && is_high && !string_last) ? code_unit[9:0] : 10'h0;
        end
    end

    // Encode the flushed surrogate and the main code point in parallel.
    assign held_enc = u16u8_pkg::encode_cp({5'h0, u16u8_pkg::HIGH_SURR_FIRST[15:10],
                                            held_bits_reg});
    assign main_enc = u16u8_pkg::encode_cp(main_cp);

    // Pack the bytes of the item, a flushed surrogate first.
    always_comb begin
        job.string_last = string_last;
        if (flush_held) begin
            job.bytes = {held_enc.bytes[31:8], main_enc.bytes[31:8]};
            job.len   = has_main ? (held_enc.len + main_enc.len) : held_enc.len;
        end else begin
            job.bytes = {main_enc.bytes, 16'h0};
            job.len   = main_enc.len;
        end
    end

    assign push = accept && (flush_held || has_main);

    // Held high surrogate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_bits_reg  <= 10'h0;
        end else begin
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

endmodule

[rtl/u16u8_queue.sv]
module u16u8_queue #(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  u16u8_pkg::job_t  push_job,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output u16u8_pkg::job_t  pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    u16u8_pkg::job_t  entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_job   = entries[rd_ptr_reg];

    // Pointer and fill count update with wraparound at any depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[rtl/u16u8_back.sv]
module u16u8_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_not_empty,
    input  u16u8_pkg::job_t  q_job,
    output logic             q_pop,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             string_done,
    output logic             out_valid,
    input  logic             out_ready
);

    localparam int BYTES_W = 8 * u16u8_pkg::MAX_BYTES;

    logic                          cur_valid_reg;
    logic                          cur_valid_next;
    logic [BYTES_W-1:0]            cur_bytes_reg;
    logic [BYTES_W-1:0]            cur_bytes_next;
    logic [u16u8_pkg::LEN_W-1:0]   cur_left_reg;
    logic [u16u8_pkg::LEN_W-1:0]   cur_left_next;
    logic                          cur_last_reg;
    logic                          cur_last_next;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       run_last_reg;
    logic       string_done_reg;

    logic out_free;
    logic emit;
    logic finishing;

    // A byte moves to the output register whenever that register frees up and an item is loaded.
    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = out_free && cur_valid_reg;
    assign finishing = emit && (cur_left_reg == u16u8_pkg::LEN_W'(1));
    assign q_pop     = q_not_empty && (!cur_valid_reg || finishing);

    // Current item: load from the queue or shift out one byte.
    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_bytes_next = cur_bytes_reg;
        cur_left_next  = cur_left_reg;
        cur_last_next  = cur_last_reg;
        if (q_pop) begin
            cur_valid_next = 1'b1;
            cur_bytes_next = q_job.bytes;
            cur_left_next  = q_job.len;
            cur_last_next  = q_job.string_last;
        end else if (emit) begin
            cur_valid_next = !finishing;
            cur_bytes_next = {cur_bytes_reg[BYTES_W-9:0], 8'h0};
            cur_left_next  = cur_left_reg - 1'b1;
        end
    end

    assign out_valid_next = out_free ? emit : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_bytes_reg <= cur_bytes_next;
        cur_left_reg  <= cur_left_next;
        cur_last_reg  <= cur_last_next;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_byte_reg    <= cur_bytes_reg[BYTES_W-1 -: 8];
            run_last_reg    <= finishing;
            string_done_reg <= finishing && cur_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign run_last    = run_last_reg;
    assign string_done = string_done_reg;

endmodule
